/* rtl/ecvf_pkg.sv */
// Shared types, constants and register codes for the elevation column voxel fill block.
`default_nettype none

package ecvf_pkg;

  // Default geometry
  localparam int CELLS_DEF  = 16384;
  localparam int LAYERS_DEF = 64;

  // Field widths
  localparam int IDX_W      = 14;
  localparam int DATA_W     = 32;
  localparam int THICK_W    = 31;
  localparam int LAYER_W    = 6;
  localparam int CNT_W      = 7;
  localparam int MODE_W     = 2;
  localparam int BOUND_W    = 40;
  localparam int VOXEL_W    = DATA_W + 1;
  localparam int REG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  // Register indexes (byte address is 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_VOLUME_BOTTOM   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LAYER_THICKNESS = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LAYERS_IN_USE   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_UPPER_FILL      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LOWER_FILL      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_UPPER_MODE      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_LOWER_MODE      = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_PASS      = 3'd7;

  // Fill rule codes; the unused code behaves as null/keep
  localparam logic [MODE_W-1:0] MODE_KEEP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CELL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FILL = 2'd2;

  // Register reset values
  localparam logic [THICK_W-1:0] THICK_RST  = 31'd65536;
  localparam logic [CNT_W-1:0]   LAYERS_RST = 7'd64;

  typedef struct packed {
    logic signed [DATA_W-1:0] volume_bottom;
    logic [THICK_W-1:0]       layer_thickness;
    logic [CNT_W-1:0]         layers_in_use;
    logic signed [DATA_W-1:0] upper_fill;
    logic signed [DATA_W-1:0] lower_fill;
    logic [MODE_W-1:0]        upper_mode;
    logic [MODE_W-1:0]        lower_mode;
    logic                     first_pass;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]         cell_index;
    logic signed [DATA_W-1:0] elevation;
    logic                     elevation_null;
    logic signed [DATA_W-1:0] cell_value;
    logic                     value_null;
  } cell_t;

  typedef struct packed {
    logic [LAYER_W-1:0]       layer;
    logic signed [DATA_W-1:0] voxel_value;
    logic                     voxel_null;
    logic                     last_layer;
  } voxel_t;

  // Sequencer controls toward the layer unit
  typedef struct packed {
    logic init;   // load the bounds of layer zero
    logic rd_en;  // read the voxel store
    logic wr_en;  // finish one layer: write voxel, advance bounds
  } ctl_t;

endpackage

`default_nettype wire

/* rtl/ecvf_cfg_regs.sv */
// APB-style configuration register file.
`default_nettype none

module ecvf_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [ecvf_pkg::REG_ADDR_W-1:0]    paddr,
  input  wire logic [ecvf_pkg::DATA_W-1:0]        pwdata,
  output logic      [ecvf_pkg::DATA_W-1:0]        prdata,
  output logic                                    pready,
  output ecvf_pkg::cfg_t                          cfg
);
  import ecvf_pkg::*;

  logic                 wr;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[REG_ADDR_W-1:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.volume_bottom   <= '0;
      cfg.layer_thickness <= THICK_RST;
      cfg.layers_in_use   <= LAYERS_RST;
      cfg.upper_fill      <= '0;
      cfg.lower_fill      <= '0;
      cfg.upper_mode      <= MODE_KEEP;
      cfg.lower_mode      <= MODE_KEEP;
      cfg.first_pass      <= 1'b1;
    end else if (wr) begin
      unique case (idx)
        REG_VOLUME_BOTTOM:   cfg.volume_bottom   <= pwdata;
        REG_LAYER_THICKNESS: cfg.layer_thickness <= pwdata[THICK_W-1:0];
        REG_LAYERS_IN_USE:   cfg.layers_in_use   <= pwdata[CNT_W-1:0];
        REG_UPPER_FILL:      cfg.upper_fill      <= pwdata;
        REG_LOWER_FILL:      cfg.lower_fill      <= pwdata;
        REG_UPPER_MODE:      cfg.upper_mode      <= pwdata[MODE_W-1:0];
        REG_LOWER_MODE:      cfg.lower_mode      <= pwdata[MODE_W-1:0];
        REG_FIRST_PASS:      cfg.first_pass      <= pwdata[0];
      endcase
    end
  end

  // Readback
  always_comb begin
    unique case (idx)
      REG_VOLUME_BOTTOM:   prdata = cfg.volume_bottom;
      REG_LAYER_THICKNESS: prdata = {1'b0, cfg.layer_thickness};
      REG_LAYERS_IN_USE:   prdata = {{(DATA_W-CNT_W){1'b0}}, cfg.layers_in_use};
      REG_UPPER_FILL:      prdata = cfg.upper_fill;
      REG_LOWER_FILL:      prdata = cfg.lower_fill;
      REG_UPPER_MODE:      prdata = {{(DATA_W-MODE_W){1'b0}}, cfg.upper_mode};
      REG_LOWER_MODE:      prdata = {{(DATA_W-MODE_W){1'b0}}, cfg.lower_mode};
      REG_FIRST_PASS:      prdata = {{(DATA_W-1){1'b0}}, cfg.first_pass};
    endcase
  end

endmodule

`default_nettype wire

/* rtl/ecvf_layer_unit.sv */
// Layer datapath: shared bound adder, elevation compares, fill rules and the voxel store.
`default_nettype none

module ecvf_layer_unit #(
  parameter int CELLS  = ecvf_pkg::CELLS_DEF,
  parameter int LAYERS = ecvf_pkg::LAYERS_DEF,
  parameter int AW     = 1
) (
  input  wire logic                            clk,
  input  wire ecvf_pkg::cfg_t                  cfg,
  input  wire ecvf_pkg::cell_t                 cell_data,
  input  wire ecvf_pkg::ctl_t                  ctl,
  input  wire logic [AW-1:0]                   wr_addr,
  input  wire logic [AW-1:0]                   rd_addr,
  output logic signed [ecvf_pkg::DATA_W-1:0]   voxel_value,
  output logic                                 voxel_null
);
  import ecvf_pkg::*;

  localparam int DEPTH = CELLS * LAYERS;

  logic [VOXEL_W-1:0]        mem [DEPTH];
  logic [VOXEL_W-1:0]        rd_data;
  logic signed [BOUND_W-1:0] lo;
  logic signed [BOUND_W-1:0] hi;
  logic signed [BOUND_W-1:0] add_a;
  logic signed [BOUND_W-1:0] add_sum;
  logic signed [BOUND_W-1:0] bottom_ext;
  logic signed [BOUND_W-1:0] thick_ext;
  logic signed [BOUND_W-1:0] elev_ext;
  logic [VOXEL_W-1:0]        cellv;
  logic [VOXEL_W-1:0]        keep_v;
  logic [VOXEL_W-1:0]        pick;
  logic [MODE_W-1:0]         side_mode;
  logic signed [DATA_W-1:0]  side_fill;

  assign bottom_ext = {{(BOUND_W-DATA_W){cfg.volume_bottom[DATA_W-1]}}, cfg.volume_bottom};
  assign thick_ext  = {{(BOUND_W-THICK_W){1'b0}}, cfg.layer_thickness};
  assign elev_ext   = {{(BOUND_W-DATA_W){cell_data.elevation[DATA_W-1]}}, cell_data.elevation};

  // Shared bound adder: top of the next layer
  assign add_a   = ctl.init ? bottom_ext : hi;
  assign add_sum = add_a + thick_ext;

  always_ff @(posedge clk) begin
    if (ctl.init || ctl.wr_en) begin
      lo <= add_a;
      hi <= add_sum;
    end
  end

  // Fill rule selection for the current layer
  assign cellv  = cell_data.value_null ? {1'b1, {DATA_W{1'b0}}}
                                       : {1'b0, cell_data.cell_value};
  assign keep_v = cfg.first_pass ? {1'b1, {DATA_W{1'b0}}} : rd_data;

  always_comb begin
    if (elev_ext < lo) begin
      side_mode = cfg.upper_mode;
      side_fill = cfg.upper_fill;
    end else begin
      side_mode = cfg.lower_mode;
      side_fill = cfg.lower_fill;
    end
    if (cell_data.elevation_null) begin
      pick = keep_v;
    end else if (elev_ext >= lo && elev_ext <= hi) begin
      pick = cellv;
    end else begin
      case (side_mode)
        MODE_CELL: pick = cellv;
        MODE_FILL: pick = {1'b0, side_fill};
        default:   pick = keep_v;
      endcase
    end
  end

  // Null voxels carry a zero value
  assign voxel_null  = pick[DATA_W];
  assign voxel_value = pick[DATA_W] ? '0 : pick[DATA_W-1:0];

  // Voxel store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= {voxel_null, voxel_value};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/elevation_column_voxel_fill.sv */
// Top level: cell sequencer, output register and configuration port.
`default_nettype none

// Takes one map cell per item and emits one voxel per layer, bottom layer
// first, each written back to an internal voxel store of CELLS*LAYERS
// entries of 33 bits (not cleared at reset; later passes must only read
// entries an earlier pass wrote). Each item, with its layer count (saturated
// at LAYERS), goes through these steps: an accept step that also forms the
// quotient of the cell index by CELLS with a reciprocal multiply, a step for
// the remainder, one forming the store address, one priming the store read,
// then one layer per cycle while the output is not stalled, through the
// shared 40-bit bound adder and the store's single read and write port.
// A stalled output holds the layer sequence while layers are pending.
// cell_stall stays high until the last voxel is loaded into the output
// register. A layer count of zero produces no voxels and the sequencer
// stays idle.
module elevation_column_voxel_fill #(
  parameter int CELLS  = ecvf_pkg::CELLS_DEF,
  parameter int LAYERS = ecvf_pkg::LAYERS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [ecvf_pkg::REG_ADDR_W-1:0]    paddr,
  input  wire logic [ecvf_pkg::DATA_W-1:0]        pwdata,
  output logic      [ecvf_pkg::DATA_W-1:0]        prdata,
  output logic                                    pready,
  input  wire logic                               cell_valid,
  output logic                                    cell_stall,
  input  wire ecvf_pkg::cell_t                    cell_data,
  output logic                                    voxel_valid,
  input  wire logic                               voxel_stall,
  output ecvf_pkg::voxel_t                        voxel
);
  import ecvf_pkg::*;

  localparam int AW    = (CELLS * LAYERS > 1) ? $clog2(CELLS * LAYERS) : 1;
  // Reciprocal for index / CELLS, exact over the whole index range
  localparam int     RED_S   = IDX_W + $clog2(CELLS);
  localparam longint RED_M   = ((longint'(1) << RED_S) + longint'(CELLS) - 1)
                               / longint'(CELLS);
  localparam logic [IDX_W+1:0] RED_MUL = (IDX_W+2)'(RED_M);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REDUCE = 5'b00010,
    S_BASE   = 5'b00100,
    S_PRIME  = 5'b01000,
    S_RUN    = 5'b10000
  } state_t;

  state_t                   state;
  cfg_t                     cfg;
  cell_t                    cell_r;
  ctl_t                     ctl;
  logic [IDX_W-1:0]         rem;
  logic [IDX_W-1:0]         q;
  logic [2*IDX_W+1:0]       q_prod;
  logic [CNT_W-1:0]         count_sat;
  logic [CNT_W-1:0]         count_r;
  logic [LAYER_W-1:0]       z;
  logic [AW-1:0]            addr;
  logic [AW-1:0]            rd_addr;
  logic                     accept;
  logic                     step;
  logic                     last;
  logic signed [DATA_W-1:0] unit_value;
  logic                     unit_null;

  ecvf_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake and sequencing terms
  assign cell_stall = (state != S_IDLE);
  assign accept     = cell_valid && !cell_stall;
  assign step       = (state == S_RUN) && (!voxel_valid || !voxel_stall);
  assign last       = ({1'b0, z} + CNT_W'(1)) == count_r;
  assign count_sat  = (cfg.layers_in_use > CNT_W'(LAYERS)) ? CNT_W'(LAYERS)
                                                           : cfg.layers_in_use;
  assign q_prod     = {{(IDX_W+2){1'b0}}, cell_data.cell_index} * {{IDX_W{1'b0}}, RED_MUL};
  assign rd_addr    = (state == S_PRIME) ? addr : addr + AW'(1);

  assign ctl.init  = accept;
  assign ctl.rd_en = (state == S_PRIME) || (step && !last);
  assign ctl.wr_en = step;

  ecvf_layer_unit #(
    .CELLS  (CELLS),
    .LAYERS (LAYERS),
    .AW     (AW)
  ) u_layer (
    .clk         (clk),
    .cfg         (cfg),
    .cell_data   (cell_r),
    .ctl         (ctl),
    .wr_addr     (addr),
    .rd_addr     (rd_addr),
    .voxel_value (unit_value),
    .voxel_null  (unit_null)
  );

  // Sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      voxel_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && count_sat != '0) begin
            state <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          state <= S_BASE;
        end
        S_BASE: begin
          state <= S_PRIME;
        end
        S_PRIME: begin
          state <= S_RUN;
        end
        S_RUN: begin
          if (step && last) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (step) begin
        voxel_valid <= 1'b1;
      end else if (!voxel_valid || !voxel_stall) begin
        voxel_valid <= 1'b0;
      end
    end
  end

  // Item latch, index reduction, address and layer counters
  always_ff @(posedge clk) begin
    if (accept) begin
      cell_r  <= cell_data;
      q       <= IDX_W'(q_prod >> RED_S);
      count_r <= count_sat;
      z       <= '0;
    end
    // Quotient is zero whenever CELLS exceeds the index range
    if (state == S_REDUCE) begin
      rem <= cell_r.cell_index - q * IDX_W'(CELLS);
    end
    if (state == S_BASE) begin
      addr <= AW'(rem * LAYERS);
    end
    if (step) begin
      addr <= addr + AW'(1);
      z    <= z + LAYER_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (step) begin
      voxel.layer       <= z;
      voxel.voxel_value <= unit_value;
      voxel.voxel_null  <= unit_null;
      voxel.last_layer  <= last;
    end
  end

`ifndef NO_ASSERTIONS
  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (step && last) |=> (state == S_IDLE))
    else $error("sequencer did not return to idle after the last layer");

  a_layer_advance: assert property (@(posedge clk) disable iff (rst)
    (step && !last) |=> (z == $past(z) + LAYER_W'(1)))
    else $error("layer counter did not advance by one");

  a_reduced_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_BASE) |-> (int'(rem) < CELLS))
    else $error("cell index not reduced below the cell count");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> !accept)
    else $error("item accepted while layers are in progress");
`endif

endmodule

`default_nettype wire
